// File: rtl/pbd_pkg.sv
`default_nettype none

package pbd_pkg;

    // field widths fixed by the item formats
    localparam int CH_FIELD_W = 3;
    localparam int LEVEL_W    = 7;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 7'd127;

    // action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS  = 2'd3;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_ACTIVE_MASK = 8'hFF;
    localparam logic [CFG_DATA_W-1:0] RST_LOCAL_MASK  = 8'hFF;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_TICKS  = 8'd200;
    localparam logic [CFG_DATA_W-1:0] RST_RAMP_TICKS  = 8'd10;

    // defaults for top-level parameters
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_QUEUE_DEPTH = 2;

    // queued command, front to back
    typedef struct packed {
        logic                  is_tick;
        logic [CH_FIELD_W-1:0] channel;
        logic                  pressed;
    } t_cmd;

    // configuration seen by the back end
    typedef struct packed {
        logic [CFG_DATA_W-1:0] active_mask;
        logic [CFG_DATA_W-1:0] local_mask;
        logic [TICK_W-1:0]     hold_ticks;
        logic [TICK_W-1:0]     ramp_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/pbd_in_if.sv
`default_nettype none

interface pbd_in_if;
    import pbd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [CH_FIELD_W-1:0] channel;
    logic                  pressed;

    modport source (output valid, output action, output channel, output pressed,
                    input ready);
    modport sink   (input valid, input action, input channel, input pressed,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/pbd_out_if.sv
`default_nettype none

interface pbd_out_if;
    import pbd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CH_FIELD_W-1:0] lamp;
    logic [LEVEL_W-1:0]    level;
    logic                  changed;

    modport source (output valid, output lamp, output level, output changed,
                    input ready);
    modport sink   (input valid, input lamp, input level, input changed,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/pbd_front.sv
`default_nettype none

// Accepts input words, drops polls of missing channels, queues the rest.
module pbd_front #(
    parameter int CHANNELS = pbd_pkg::DEF_CHANNELS
) (
    pbd_in_if.sink          i_in,
    input  wire logic       i_q_full,
    output logic            o_push,
    output pbd_pkg::t_cmd   o_cmd
);
    import pbd_pkg::*;

    logic keep;

    assign i_in.ready = !i_q_full;

    always_comb begin
        keep = (i_in.action == ACT_TICK) ||
               ({1'b0, i_in.channel} < (CH_FIELD_W + 1)'(CHANNELS));
        o_push          = i_in.valid && !i_q_full && keep;
        o_cmd.is_tick   = (i_in.action == ACT_TICK);
        o_cmd.channel   = i_in.channel;
        o_cmd.pressed   = i_in.pressed;
    end

endmodule

`default_nettype wire

// File: rtl/pbd_fifo.sv
`default_nettype none

// Small command queue; DEPTH is a power of two, at least 2.
module pbd_fifo #(
    parameter int DEPTH = pbd_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pbd_pkg::t_cmd  i_data,
    output logic                o_full,
    output logic                o_valid,
    output pbd_pkg::t_cmd       o_data,
    input  wire logic           i_pop
);
    import pbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/pbd_back.sv
`default_nettype none

// Executes queued commands: tick counter, per-channel dimmer state,
// result register toward the output channel.
module pbd_back #(
    parameter int CHANNELS = pbd_pkg::DEF_CHANNELS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pbd_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire pbd_pkg::t_cmd  i_cmd,
    output logic                o_pop,
    pbd_out_if.source           o_out
);
    import pbd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [TICK_W-1:0]  r_tick;
    logic [LEVEL_W-1:0] r_bright   [CHANNELS];
    logic               r_up       [CHANNELS];
    logic               r_was      [CHANNELS];
    logic               r_ramp     [CHANNELS];
    logic [TICK_W-1:0]  r_rel      [CHANNELS];
    logic [TICK_W-1:0]  r_stp      [CHANNELS];

    logic                  r_ov;
    logic [CH_FIELD_W-1:0] r_lamp;
    logic [LEVEL_W-1:0]    r_level;
    logic                  r_changed;

    logic [IDX_W-1:0]   idx;
    logic               load;
    logic               act, dim;
    logic [TICK_W-1:0]  since_rel, since_stp;
    logic [LEVEL_W-1:0] cur_b, n_b;
    logic               n_up, n_was, n_ramp, chg;
    logic [TICK_W-1:0]  n_rel, n_stp;

    // ticks never wait on the output; polls wait for a free result slot
    assign o_pop = i_valid && (i_cmd.is_tick || !r_ov || o_out.ready);
    assign load  = o_pop && !i_cmd.is_tick;
    assign idx   = i_cmd.channel[IDX_W-1:0];

    assign o_out.valid   = r_ov;
    assign o_out.lamp    = r_lamp;
    assign o_out.level   = r_level;
    assign o_out.changed = r_changed;

    always_comb begin
        act       = i_cfg.active_mask[i_cmd.channel];
        dim       = act && i_cfg.local_mask[i_cmd.channel];
        cur_b     = r_bright[idx];
        since_rel = r_tick - r_rel[idx];
        since_stp = r_tick - r_stp[idx];
        n_b       = cur_b;
        n_up      = r_up[idx];
        n_was     = r_was[idx];
        n_ramp    = r_ramp[idx];
        n_rel     = r_rel[idx];
        n_stp     = r_stp[idx];
        chg       = 1'b0;
        // virtual channel: button ignored
        if (!(act && !dim)) begin
            if (i_cmd.pressed) begin
                n_was = 1'b1;
                if (((since_rel > i_cfg.hold_ticks) || r_ramp[idx]) && dim) begin
                    n_ramp = 1'b1;
                    if (since_stp > i_cfg.ramp_ticks) begin
                        if (r_up[idx]) begin
                            n_b  = (cur_b < MAX_LEVEL) ? cur_b + 1'b1 : cur_b;
                            n_up = !(n_b >= MAX_LEVEL);
                        end else begin
                            n_b  = (cur_b != '0) ? cur_b - 1'b1 : cur_b;
                            n_up = (n_b == '0);
                        end
                        chg   = (n_b != cur_b);
                        n_stp = r_tick;
                    end
                end else begin
                    n_stp = r_tick;
                end
            end else begin
                if (r_was[idx]) begin
                    n_was = 1'b0;
                    if (r_ramp[idx]) begin
                        n_ramp = 1'b0;
                        n_up   = !r_up[idx];
                    end else if (cur_b == '0) begin
                        n_b  = MAX_LEVEL;
                        n_up = 1'b0;
                        chg  = 1'b1;
                    end else begin
                        n_b  = '0;
                        n_up = 1'b1;
                        chg  = 1'b1;
                    end
                end
                n_rel = r_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_bright[c] <= '0;
                r_up[c]     <= 1'b1;
                r_was[c]    <= 1'b0;
                r_ramp[c]   <= 1'b0;
                r_rel[c]    <= '0;
                r_stp[c]    <= '0;
            end
        end else begin
            if (o_pop && i_cmd.is_tick) begin
                r_tick <= r_tick + 1'b1;
            end
            if (load) begin
                r_bright[idx] <= n_b;
                r_up[idx]     <= n_up;
                r_was[idx]    <= n_was;
                r_ramp[idx]   <= n_ramp;
                r_rel[idx]    <= n_rel;
                r_stp[idx]    <= n_stp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lamp    <= i_cmd.channel;
            r_level   <= n_b;
            r_changed <= chg;
        end
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_level <= MAX_LEVEL))
        else $error("result level above maximum");

    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.is_tick) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick counter did not advance");

    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_changed == (r_level != $past(cur_b))))
        else $error("changed flag disagrees with level");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/push_button_dimmer_control_top.sv
// Push-button dimmer control, up to eight lamp channels.
//
// Input channel i_in: one word per handshake. action = tick advances the
// shared 8-bit half-cycle counter and gives no result; action = poll reports
// the button of one channel and gives one result word on o_out (lamp, level,
// changed). Polls of channels at or above CHANNELS are taken and dropped.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 active_mask, 1 local_mask, 2 hold_ticks, 3 ramp_ticks); write only
// while no word is in flight.
// Throughput: one word per cycle while the queue has room and o_out takes
// results. A poll's word is written into the queue on acceptance; the back
// end then pops it and loads the result register toward o_out.
// The back end reads, modifies and writes back the channel state on the pop.
// When o_out stalls, ticks at the queue head keep draining; polls wait in
// the queue and i_in.ready drops once the queue is full.
// Reset (synchronous, i_rst_n low): all levels 0, direction up, no press,
// counter and time stamps 0, registers back to their default values.
`default_nettype none

module push_button_dimmer_control_top #(
    parameter int CHANNELS    = pbd_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH = pbd_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pbd_in_if.sink                                i_in,
    pbd_out_if.source                             o_out
);
    import pbd_pkg::*;

    t_cfg r_cfg;
    t_cmd q_in, q_out;
    logic q_push, q_full, q_valid, q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_mask <= RST_ACTIVE_MASK;
            r_cfg.local_mask  <= RST_LOCAL_MASK;
            r_cfg.hold_ticks  <= RST_HOLD_TICKS;
            r_cfg.ramp_ticks  <= RST_RAMP_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_MASK: r_cfg.active_mask <= i_cfg_data;
                CFG_LOCAL_MASK:  r_cfg.local_mask  <= i_cfg_data;
                CFG_HOLD_TICKS:  r_cfg.hold_ticks  <= i_cfg_data;
                CFG_RAMP_TICKS:  r_cfg.ramp_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    pbd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // decoupling queue
    pbd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    // back: state update and result register
    pbd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
    import pbd_pkg::*;

    // Run limits. The slowest correct run stays well below the limit.
    localparam int CYCLE_LIMIT = 300000;
    // After the last result word, ticks may still sit in the front queue.
    localparam int SETTLE_CYCLES = 8;
    // Long receiver hold-off: starts once this many words were sent.
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 27;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // one directed stimulus row; typed = 1 means the expected word is given here
    typedef struct {
        t_row_kind              kind;
        logic                   action;
        logic [CH_FIELD_W-1:0]  channel;
        logic                   pressed;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        logic [LEVEL_W-1:0]     level;
        logic                   changed;
    } t_dir_row;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] lamp;
        logic [LEVEL_W-1:0]    level;
        logic                  changed;
    } t_lamp_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pbd_in_if  in_bus ();
    pbd_out_if out_bus ();

    push_button_dimmer_control_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Dimmer predictor: own copy of registers and per-channel state.
    // ------------------------------------------------------------------
    logic [7:0]         cfg_active;
    logic [7:0]         cfg_local;
    logic [7:0]         cfg_hold;
    logic [7:0]         cfg_ramp;
    logic [TICK_W-1:0]  tick_now;
    logic [LEVEL_W-1:0] lamp_level  [8];
    logic               ramp_up     [8];
    logic               btn_held    [8];
    logic               btn_ramping [8];
    logic [TICK_W-1:0]  released_at [8];
    logic [TICK_W-1:0]  stepped_at  [8];

    t_lamp_word lamp_expect_q [$];

    int  err_count       = 0;
    int  words_sent      = 0;
    int  cycle_count     = 0;
    bit  steady          = 1'b0;  // final stretch: no idling anywhere
    bit  gap_on          = 1'b1;  // sender idles in bursts when set
    bit  long_hold_done  = 1'b0;

    // Applies one input word to the predicted state. Returns 1 when the word
    // yields a result word (every poll; with 8 channels no poll is dropped).
    function automatic bit dimmer_next(input logic act, input logic [CH_FIELD_W-1:0] ch,
                                       input logic prs, output t_lamp_word res);
        logic               act_ch;
        logic               dim_ch;
        logic               moved;
        logic [LEVEL_W-1:0] was;
        logic [TICK_W-1:0]  held_for;
        logic [TICK_W-1:0]  since_step;
        res   = '0;
        moved = 1'b0;
        if (act == ACT_TICK) begin
            tick_now = tick_now + 8'd1;
            return 1'b0;
        end
        act_ch     = cfg_active[ch];
        dim_ch     = act_ch && cfg_local[ch];
        held_for   = tick_now - released_at[ch];
        since_step = tick_now - stepped_at[ch];
        // virtual channel: button ignored, state untouched
        if (!(act_ch && !dim_ch)) begin
            if (prs) begin
                btn_held[ch] = 1'b1;
                if ((held_for > cfg_hold || btn_ramping[ch]) && dim_ch) begin
                    btn_ramping[ch] = 1'b1;
                    if (since_step > cfg_ramp) begin
                        was = lamp_level[ch];
                        // clamped step, direction flips at either end
                        if (ramp_up[ch]) begin
                            if (lamp_level[ch] < MAX_LEVEL) lamp_level[ch] = lamp_level[ch] + 7'd1;
                            if (lamp_level[ch] >= MAX_LEVEL) ramp_up[ch] = 1'b0;
                        end else begin
                            if (lamp_level[ch] > 7'd0) lamp_level[ch] = lamp_level[ch] - 7'd1;
                            if (lamp_level[ch] == 7'd0) ramp_up[ch] = 1'b1;
                        end
                        moved          = (lamp_level[ch] != was);
                        stepped_at[ch] = tick_now;
                    end
                end else begin
                    stepped_at[ch] = tick_now;
                end
            end else begin
                if (btn_held[ch]) begin
                    btn_held[ch] = 1'b0;
                    if (btn_ramping[ch]) begin
                        btn_ramping[ch] = 1'b0;
                        ramp_up[ch]     = !ramp_up[ch];
                    end else if (lamp_level[ch] == 7'd0) begin
                        lamp_level[ch] = MAX_LEVEL;
                        ramp_up[ch]    = 1'b0;
                        moved          = 1'b1;
                    end else begin
                        lamp_level[ch] = 7'd0;
                        ramp_up[ch]    = 1'b1;
                        moved          = 1'b1;
                    end
                end
                released_at[ch] = tick_now;
            end
        end
        res.lamp    = ch;
        res.level   = lamp_level[ch];
        res.changed = moved;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one word and holds it until taken. On acceptance the predictor
    // runs; a typed row supplies its own expected word instead.
    task automatic send_word(input logic act, input logic [CH_FIELD_W-1:0] ch,
                             input logic prs, input logic typed, input t_lamp_word typed_w);
        t_lamp_word w;
        int         n;
        in_bus.valid   <= 1'b1;
        in_bus.action  <= act;
        in_bus.channel <= ch;
        in_bus.pressed <= prs;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        words_sent++;
        if (dimmer_next(act, ch, prs, w)) begin
            lamp_expect_q.push_back(typed ? typed_w : w);
        end
        // idle burst; the fields carry junk while valid is low
        if (!steady && gap_on && $urandom_range(0, 3) == 0) begin
            in_bus.valid   <= 1'b0;
            in_bus.action  <= 1'($urandom);
            in_bus.channel <= 3'($urandom);
            in_bus.pressed <= 1'($urandom);
            n = $urandom_range(1, 10);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic poll(input logic [CH_FIELD_W-1:0] ch, input logic prs);
        send_word(ACT_POLL, ch, prs, 1'b0, '0);
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_word(ACT_TICK, 3'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // Drops valid, waits for every expected word, then lets trailing ticks
    // drain through the front queue.
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (lamp_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; write enable drops between writes so back-to-back
    // writes never see two assignments in one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE_MASK: cfg_active = data;
            CFG_LOCAL_MASK:  cfg_local  = data;
            CFG_HOLD_TICKS:  cfg_hold   = data;
            CFG_RAMP_TICKS:  cfg_ramp   = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Release, wait out the hold time (or less), then a series of pressed polls
    // spaced for a ramp step each (or closer), then release again.
    task automatic press_hold(input logic [CH_FIELD_W-1:0] ch, input int steps);
        int pre;
        int gap;
        poll(ch, 1'b0);
        if (cfg_hold <= 8'd32 || $urandom_range(0, 1) == 1) pre = int'(cfg_hold) + 1;
        else pre = $urandom_range(0, 8);
        if (pre > 255) pre = 255;
        tick_n(pre);
        repeat (steps) begin
            if (cfg_ramp <= 8'd8 || $urandom_range(0, 2) == 0) begin
                gap = int'(cfg_ramp) + $urandom_range(1, 2);
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap > 255) gap = 255;
            tick_n(gap);
            poll(ch, 1'b1);
        end
        poll(ch, 1'b0);
    endtask

    // Directed rows. Expected words are typed where they follow directly from the
    // state after reset and the rows before; the rest go through the predictor.
    t_dir_row dir_rows [N_DIR] = '{
        // after reset: release polls at both channel extremes
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd7, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        // tick with junk fields: no result
        '{ROW_WORD, ACT_TICK, 3'd7, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        // short press toggles 0 -> max -> 0
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd127, 1'b1},
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd127, 1'b0},
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b1},
        // short hold, shortest ramp: a few ramp steps, then release flips direction
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_HOLD_TICKS,  8'd1,  1'b0, 7'd0,   1'b0},
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_RAMP_TICKS,  8'd0,  1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd3, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_TICK, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_TICK, 3'd5, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd3, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_TICK, 3'd2, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd3, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd3, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd3, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        // channel 0 on/off only, channel 7 virtual
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'hFE, 1'b0, 7'd0,   1'b0},
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_LOCAL_MASK,  8'h7F, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd7, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd7, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd0, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b1, 7'd127, 1'b1},
        // hold that can never be exceeded, longest ramp spacing
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_HOLD_TICKS,  8'd255, 1'b0, 7'd0,  1'b0},
        '{ROW_CFG,  ACT_TICK, 3'd0, 1'b0, CFG_RAMP_TICKS,  8'd254, 1'b0, 7'd0,  1'b0},
        '{ROW_WORD, ACT_POLL, 3'd5, 1'b0, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0},
        '{ROW_WORD, ACT_POLL, 3'd5, 1'b1, CFG_ACTIVE_MASK, 8'h00, 1'b0, 7'd0,   1'b0}
    };

    // Main stimulus: reset, directed rows, then phases of random sequences,
    // each phase under its own register setting.
    initial begin
        int                    budget_end;
        int                    r;
        int                    steps;
        logic [CH_FIELD_W-1:0] ch;
        logic [7:0]            set_active;
        logic [7:0]            set_local;
        logic [7:0]            set_hold;
        logic [7:0]            set_ramp;
        int                    budget;

        cfg_active = RST_ACTIVE_MASK;
        cfg_local  = RST_LOCAL_MASK;
        cfg_hold   = RST_HOLD_TICKS;
        cfg_ramp   = RST_RAMP_TICKS;
        tick_now   = '0;
        for (int c = 0; c < 8; c++) begin
            lamp_level[c]  = '0;
            ramp_up[c]     = 1'b1;
            btn_held[c]    = 1'b0;
            btn_ramping[c] = 1'b0;
            released_at[c] = '0;
            stepped_at[c]  = '0;
        end

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_ACTIVE_MASK;
        i_cfg_data     <= '0;
        in_bus.valid   <= 1'b0;
        in_bus.action  <= ACT_TICK;
        in_bus.channel <= '0;
        in_bus.pressed <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_word(dir_rows[i].action, dir_rows[i].channel, dir_rows[i].pressed,
                          dir_rows[i].typed,
                          '{dir_rows[i].channel, dir_rows[i].level, dir_rows[i].changed});
            end
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin  // fastest ramping, all dimmable
                    set_active = 8'hFF; set_local = 8'hFF;
                    set_hold = 8'd1; set_ramp = 8'd0; budget = 100;
                end
                1: begin
                    set_active = 8'hFF; set_local = 8'hFF;
                    set_hold = 8'd3; set_ramp = 8'd1; budget = 120;
                end
                2: begin  // mixed modes per channel
                    set_active = 8'($urandom); set_local = 8'($urandom);
                    set_hold = 8'($urandom_range(1, 8)); set_ramp = 8'($urandom_range(0, 3));
                    budget = 150;
                end
                3: begin  // all plain on/off
                    set_active = 8'h00; set_local = 8'h00;
                    set_hold = 8'd1; set_ramp = 8'd0; budget = 60;
                end
                4: begin  // all virtual
                    set_active = 8'hFF; set_local = 8'h00;
                    set_hold = 8'd1; set_ramp = 8'd0; budget = 40;
                end
                5: begin  // slowest legal timing
                    set_active = 8'($urandom); set_local = 8'($urandom);
                    set_hold = 8'd254; set_ramp = 8'd254; budget = 30;
                end
                6: begin  // ramping can never start
                    set_active = 8'($urandom); set_local = 8'($urandom);
                    set_hold = 8'd255; set_ramp = 8'($urandom_range(0, 254)); budget = 40;
                end
                default: begin  // final stretch, both sides busy every cycle
                    set_active = 8'hFF; set_local = 8'($urandom);
                    set_hold = 8'd2; set_ramp = 8'd1; budget = 150;
                end
            endcase

            wait_idle();
            if (p == 7) steady = 1'b1;
            cfg_write(CFG_ACTIVE_MASK, set_active);
            cfg_write(CFG_LOCAL_MASK, set_local);
            cfg_write(CFG_HOLD_TICKS, set_hold);
            cfg_write(CFG_RAMP_TICKS, set_ramp);

            // first phase walks one long ramp, mostly into the clamp at full level
            if (p == 0) press_hold(3'($urandom), 140);

            budget_end = words_sent + budget;
            while (words_sent < budget_end) begin
                gap_on = ($urandom_range(0, 4) != 0);
                ch     = 3'($urandom);
                r      = $urandom_range(0, 9);
                if (r <= 5) begin
                    steps = $urandom_range(1, (cfg_ramp > 8'd8) ? 3 : 12);
                    press_hold(ch, steps);
                end else if (r <= 7) begin
                    // short press, possibly cut off before release
                    poll(ch, 1'b0);
                    tick_n($urandom_range(0, 2));
                    repeat ($urandom_range(1, 3)) poll(ch, 1'b1);
                    if ($urandom_range(0, 3) != 0) poll(ch, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_word(1'($urandom), 3'($urandom), 1'($urandom), 1'b0, '0);
                    end
                end
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("[push_button_dimmer_control_top] OK");
        end else begin
            $display("[push_button_dimmer_control_top] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random ready bursts, one long hold-off so the front
    // queue fills and input ready drops, none in the final stretch.
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && words_sent >= HOLD_AT) begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge i_clk);
            end else begin
                out_bus.ready <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Result check: every taken result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_lamp_word want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (lamp_expect_q.size() == 0) begin
                report_mismatch("result word with nothing expected, lamp", out_bus.lamp, 0);
            end else begin
                want = lamp_expect_q.pop_front();
                if (out_bus.lamp !== want.lamp)
                    report_mismatch("lamp", out_bus.lamp, want.lamp);
                if (out_bus.level !== want.level)
                    report_mismatch("level", out_bus.level, want.level);
                if (out_bus.changed !== want.changed)
                    report_mismatch("changed", out_bus.changed, want.changed);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[push_button_dimmer_control_top] ERROR");
            $finish;
        end
    end

endmodule
